### rtl/sdr_pkg.sv
// Shared types, constants and helper functions for the stockpile deposit/reclaim block.
package sdr_pkg;

   localparam int PILE_LENGTH_DEF = 256;
   localparam int PILE_DEPTH_DEF  = 32;

   localparam int HEIGHT_W = 16;
   localparam int TALLY_W  = 24;
   localparam int SLOPE_W  = 8;
   localparam int UNITS_W  = 8;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 104;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
   localparam logic [TALLY_W-1:0]  TALLY_MAX  = '1;

   typedef enum logic [1:0] {
      CMD_STACK   = 2'd0,
      CMD_RECLAIM = 2'd1,
      CMD_REWIND  = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   localparam logic CSR_SLOPE = 1'b0;
   localparam logic CSR_FOUR  = 1'b1;

   typedef enum logic [1:0] {
      COLOR_RED    = 2'd0,
      COLOR_BLUE   = 2'd1,
      COLOR_YELLOW = 2'd2
   } color_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_NEXT, ST_UNIT, ST_CWAIT, ST_NRD, ST_NCMP, ST_NEND,
      ST_DIV, ST_TRD, ST_TWR, ST_RTRD, ST_RTWAIT, ST_RGRD, ST_ROUT, ST_EXH
   } state_type;

   // Neighbour offsets: orthogonal first, then diagonal.
   function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
      case (k)
         3'd0: return -2'sd1;
         3'd1: return 2'sd0;
         3'd2: return 2'sd0;
         3'd3: return 2'sd1;
         3'd4: return -2'sd1;
         3'd5: return -2'sd1;
         default: return 2'sd1;
      endcase
   endfunction

   function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
      case (k)
         3'd0: return 2'sd0;
         3'd1: return -2'sd1;
         3'd2: return 2'sd1;
         3'd3: return 2'sd0;
         3'd4: return -2'sd1;
         3'd5: return 2'sd1;
         3'd6: return -2'sd1;
         default: return 2'sd1;
      endcase
   endfunction

endpackage

### rtl/stockpile_deposit_reclaim_top.sv
// Top level of the stockpile deposit/reclaim block: command sequencer around grid and tally RAMs.
// Stack, per unit: pick it, fetch the drop cell, then per walk step read and
//   compare each in-grid neighbour, skip off-grid ones, end the step; divide, then update the tally.
// Reclaim: read the tally, then per row a grid read and a result, held while rsp_tready is low.
// One command at a time; the grid RAM read port sets the walk rate.
// Reset (and a clear command) sweeps both RAMs to zero, one entry per cycle, over all
//   PILE_LENGTH*PILE_DEPTH grid cells, with req_tready low.
module stockpile_deposit_reclaim_top
   import sdr_pkg::*;
#(
   parameter int PILE_LENGTH = PILE_LENGTH_DEF,
   parameter int PILE_DEPTH  = PILE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // command[1:0], drop_column[9:2], red_units[17:10], blue_units[25:18],
   // yellow_units[33:26], zero fill
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // column_index[7:0], red_count[31:8], blue_count[55:32], yellow_count[79:56],
   // row_index[85:80], cell_height[101:86], zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   // exhausted[0]
   output logic             rsp_tuser,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [7:0]       csr_wr_data
);

   localparam int CW    = $clog2(PILE_LENGTH);
   localparam int RW    = $clog2(PILE_DEPTH);
   localparam int CELLS = PILE_LENGTH * PILE_DEPTH;
   localparam int GA    = $clog2(CELLS);
   localparam int PW    = CW + 1;
   localparam int MW    = (CW > HEIGHT_W) ? CW : HEIGHT_W;
   localparam int XW    = ((CW > UNITS_W) ? CW : UNITS_W) + 1;
   localparam int TW    = 3 * TALLY_W;

   function automatic logic [GA-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
      return GA'(GA'(c) * GA'(PILE_DEPTH)) + GA'(r);
   endfunction

   // memories
   logic [HEIGHT_W-1:0] grid_mem [CELLS];
   logic [TW-1:0]       tally_mem [PILE_LENGTH];
   logic [HEIGHT_W-1:0] g_rd_ff;
   logic [TW-1:0]       t_rd_ff;
   logic                g_re, g_we, t_re, t_we;
   logic [GA-1:0]       g_raddr, g_waddr;
   logic [HEIGHT_W-1:0] g_wdata;
   logic [CW-1:0]       t_raddr, t_waddr;
   logic [TW-1:0]       t_wdata;

   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_waddr] <= g_wdata;
      if (g_re) g_rd_ff <= grid_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) tally_mem[t_waddr] <= t_wdata;
      if (t_re) t_rd_ff <= tally_mem[t_raddr];
   end

   // configuration
   logic [SLOPE_W-1:0] slope_ff;
   logic               four_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= SLOPE_W'(1);
         four_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SLOPE: slope_ff <= csr_wr_data;
            CSR_FOUR:  four_ff  <= csr_wr_data[0];
            default:   four_ff  <= four_ff;
         endcase
      end
   end

   // input fields
   cmd_type            req_cmd;
   logic [UNITS_W-1:0] req_col, req_red, req_blue, req_yellow;
   logic [XW-1:0]      col_wide;
   logic [CW-1:0]      col_clamped;

   assign req_cmd    = cmd_type'(req_tdata[1:0]);
   assign req_col    = req_tdata[9:2];
   assign req_red    = req_tdata[17:10];
   assign req_blue   = req_tdata[25:18];
   assign req_yellow = req_tdata[33:26];
   assign col_wide   = XW'(req_col);
   assign col_clamped = (col_wide > XW'(PILE_LENGTH - 1)) ? CW'(PILE_LENGTH - 1)
                                                          : col_wide[CW-1:0];

   // sequencer state
   state_type           state_ff, state_in;
   logic [GA-1:0]       sweep_ff;
   logic [CW-1:0]       col_ff, c_ff, bc_ff, nc_ff, tgt_ff;
   logic [RW-1:0]       r_ff, br_ff, nr_ff, row_ff;
   logic [HEIGHT_W-1:0] low_ff;
   logic [2:0]          k_ff;
   logic                moved_ff;
   color_type           color_ff;
   logic [UNITS_W-1:0]  left_ff, blue_ff, yellow_ff;
   logic [PW-1:0]       cursor_ff;

   logic [RSP_W-1:0]    rsp_data_ff;
   logic                rsp_valid_ff, rsp_last_ff, rsp_user_ff;
   logic                rsp_free;

   logic signed [CW+1:0] tc;
   logic signed [RW+1:0] tr;
   logic                 nb_in, nb_last;
   logic                 div_start, div_done;
   logic [HEIGHT_W-1:0]  quo;
   logic [MW-1:0]        quo_w, col_w;
   logic [CW-1:0]        target;
   logic [TALLY_W-1:0]   t_field, t_field_inc;

   assign tc = $signed({2'b00, c_ff}) + (CW+2)'(nb_dc(k_ff));
   assign tr = $signed({2'b00, r_ff}) + (RW+2)'(nb_dr(k_ff));
   assign nb_in = (tc >= 0) && (tc < $signed((CW+2)'(PILE_LENGTH))) &&
                  (tr >= 0) && (tr < $signed((RW+2)'(PILE_DEPTH)));
   assign nb_last = four_ff ? (k_ff == 3'd3) : (k_ff == 3'd7);

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   sdr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (low_ff),
      .divisor  (slope_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign quo_w  = MW'(quo);
   assign col_w  = MW'(c_ff);
   assign target = (quo_w > col_w) ? '0 : CW'(col_w - quo_w);

   always_comb begin
      case (color_ff)
         COLOR_RED:  t_field = t_rd_ff[TALLY_W-1:0];
         COLOR_BLUE: t_field = t_rd_ff[2*TALLY_W-1:TALLY_W];
         default:    t_field = t_rd_ff[TW-1:2*TALLY_W];
      endcase
      t_field_inc = (t_field == TALLY_MAX) ? t_field : t_field + TALLY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      g_re = 1'b0; g_we = 1'b0; t_re = 1'b0; t_we = 1'b0;
      g_raddr = cell_addr(c_ff, r_ff);
      g_waddr = sweep_ff;
      g_wdata = '0;
      t_raddr = tgt_ff;
      t_waddr = sweep_ff[CW-1:0];
      t_wdata = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            g_we = 1'b1;
            t_we = (sweep_ff < GA'(PILE_LENGTH));
            if (sweep_ff == GA'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_STACK:   state_in = ST_NEXT;
                  CMD_RECLAIM: state_in = (cursor_ff >= PW'(PILE_LENGTH)) ? ST_EXH : ST_RTRD;
                  CMD_REWIND:  state_in = ST_IDLE;
                  default:     state_in = ST_CLEAR;
               endcase
            end
         end
         ST_NEXT: begin
            if (left_ff != '0)               state_in = ST_UNIT;
            else if (color_ff == COLOR_YELLOW) state_in = ST_IDLE;
         end
         ST_UNIT: begin
            g_re     = 1'b1;
            g_raddr  = cell_addr(col_ff, RW'(PILE_DEPTH / 2));
            state_in = ST_CWAIT;
         end
         ST_CWAIT: state_in = ST_NRD;
         ST_NRD: begin
            if (nb_in) begin
               g_re     = 1'b1;
               g_raddr  = cell_addr(tc[CW-1:0], tr[RW-1:0]);
               state_in = ST_NCMP;
            end else if (nb_last) begin
               state_in = ST_NEND;
            end
         end
         ST_NCMP: state_in = nb_last ? ST_NEND : ST_NRD;
         ST_NEND: begin
            if (moved_ff) begin
               state_in = ST_NRD;
            end else begin
               g_we      = (low_ff != HEIGHT_MAX);
               g_waddr   = cell_addr(c_ff, r_ff);
               g_wdata   = low_ff + HEIGHT_W'(1);
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: if (div_done) state_in = ST_TRD;
         ST_TRD: begin
            t_re     = 1'b1;
            state_in = ST_TWR;
         end
         ST_TWR: begin
            t_we    = 1'b1;
            t_waddr = tgt_ff;
            t_wdata = t_rd_ff;
            case (color_ff)
               COLOR_RED:  t_wdata[TALLY_W-1:0]         = t_field_inc;
               COLOR_BLUE: t_wdata[2*TALLY_W-1:TALLY_W] = t_field_inc;
               default:    t_wdata[TW-1:2*TALLY_W]      = t_field_inc;
            endcase
            state_in = ST_NEXT;
         end
         ST_RTRD: begin
            t_re     = 1'b1;
            t_raddr  = cursor_ff[CW-1:0];
            state_in = ST_RTWAIT;
         end
         ST_RTWAIT: state_in = ST_RGRD;
         ST_RGRD: begin
            g_re     = 1'b1;
            g_raddr  = cell_addr(cursor_ff[CW-1:0], row_ff);
            state_in = ST_ROUT;
         end
         ST_ROUT: begin
            if (rsp_free) state_in = (row_ff == RW'(PILE_DEPTH - 1)) ? ST_IDLE : ST_RGRD;
         end
         ST_EXH: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: sweep_ff <= (sweep_ff == GA'(CELLS - 1)) ? '0 : sweep_ff + GA'(1);
            ST_IDLE: begin
               if (req_tvalid && req_cmd == CMD_REWIND) cursor_ff <= '0;
            end
            ST_ROUT: begin
               if (rsp_free && row_ff == RW'(PILE_DEPTH - 1)) cursor_ff <= cursor_ff + PW'(1);
            end
            default: sweep_ff <= sweep_ff;
         endcase
      end
   end

   // walk and reclaim datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            col_ff    <= col_clamped;
            color_ff  <= COLOR_RED;
            left_ff   <= req_red;
            blue_ff   <= req_blue;
            yellow_ff <= req_yellow;
            row_ff    <= '0;
         end
         ST_NEXT: begin
            if (left_ff != '0) begin
               left_ff <= left_ff - UNITS_W'(1);
            end else if (color_ff == COLOR_RED) begin
               color_ff <= COLOR_BLUE;
               left_ff  <= blue_ff;
            end else if (color_ff == COLOR_BLUE) begin
               color_ff <= COLOR_YELLOW;
               left_ff  <= yellow_ff;
            end
         end
         ST_UNIT: begin
            c_ff <= col_ff;
            r_ff <= RW'(PILE_DEPTH / 2);
         end
         ST_CWAIT: begin
            low_ff   <= g_rd_ff;
            k_ff     <= '0;
            moved_ff <= 1'b0;
         end
         ST_NRD: begin
            nc_ff <= tc[CW-1:0];
            nr_ff <= tr[RW-1:0];
            if (!nb_in && !nb_last) k_ff <= k_ff + 3'd1;
         end
         ST_NCMP: begin
            if (g_rd_ff < low_ff) begin
               low_ff   <= g_rd_ff;
               bc_ff    <= nc_ff;
               br_ff    <= nr_ff;
               moved_ff <= 1'b1;
            end
            if (!nb_last) k_ff <= k_ff + 3'd1;
         end
         ST_NEND: begin
            if (moved_ff) begin
               c_ff     <= bc_ff;
               r_ff     <= br_ff;
               k_ff     <= '0;
               moved_ff <= 1'b0;
            end
         end
         ST_DIV: if (div_done) tgt_ff <= target;
         ST_ROUT: if (rsp_free) row_ff <= row_ff + RW'(1);
         default: k_ff <= k_ff;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= (state_ff == ST_ROUT) || (state_ff == ST_EXH);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (state_ff == ST_ROUT) begin
            rsp_data_ff <= {2'b00, g_rd_ff, 6'(row_ff), t_rd_ff, 8'(cursor_ff)};
            rsp_last_ff <= (row_ff == RW'(PILE_DEPTH - 1));
            rsp_user_ff <= 1'b0;
         end else if (state_ff == ST_EXH) begin
            rsp_data_ff <= '0;
            rsp_last_ff <= 1'b0;
            rsp_user_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/sdr_divider.sv
// Radix-2 restoring divider: 16-bit height by 8-bit slope, one quotient bit per cycle.
module sdr_divider
   import sdr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [HEIGHT_W-1:0] dividend,
   input  logic [SLOPE_W-1:0]  divisor,
   output logic                done,
   output logic [HEIGHT_W-1:0] quotient
);

   logic [SLOPE_W-1:0]  rem_ff;
   logic [HEIGHT_W-1:0] quo_ff;
   logic [SLOPE_W-1:0]  div_ff;
   logic [4:0]          cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [SLOPE_W:0]    trial;

   assign trial    = {rem_ff, quo_ff[HEIGHT_W-1]};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(HEIGHT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         // zero slope acts as one
         div_ff <= (divisor == '0) ? SLOPE_W'(1) : divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_ff <= SLOPE_W'(trial - {1'b0, div_ff});
            quo_ff <= {quo_ff[HEIGHT_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[SLOPE_W-1:0];
            quo_ff <= {quo_ff[HEIGHT_W-2:0], 1'b0};
         end
      end
   end

endmodule
